FILE: src/rich_club_core_select_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rich club core select block
// Clocked on clk; the gated forms are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RICH_CLUB_CORE_SELECT_ASSERT_SVH
`define RICH_CLUB_CORE_SELECT_ASSERT_SVH

// same-cycle implication, off during reset
`define RCS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rich club core select: check failed");

// next-cycle implication, off during reset
`define RCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rich club core select: check failed");

// same-cycle implication, also active during reset
`define RCS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("rich club core select: reset check failed");

`endif

FILE: src/rcs_pkg.sv
// ---------------------------------------------------------------------------
// rcs_pkg
// Shared constants, codes and types of the rich club core select block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcs_pkg;

  localparam int NODE_DEPTH_DEF = 1024;
  localparam int COUNT_BITS_DEF = 16;
  localparam int ID_W           = 10;
  localparam int MODE_W         = 2;
  localparam int EDGE_W         = 16;
  localparam int OUT_CNT_W      = 16;
  localparam int EPOCH_BITS     = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_NBR   = 2'd1,
    MODE_END   = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic {
    CLR_SWEEP = 1'b0,
    CLR_RUN   = 1'b1
  } clr_state_t;

  typedef struct packed {
    mode_t           mode;
    logic [ID_W-1:0] node;
    logic            node_ok;
    logic            nbr_ok;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]      node;
    logic                 joined;
    logic                 done;
    logic [OUT_CNT_W-1:0] core;
    logic [OUT_CNT_W-1:0] periph;
  } result_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  wrap;
    logic [EPOCH_BITS-1:0] epoch;
  } upd_ctl_t;

  typedef struct packed {
    logic busy;
    logic wr_en;
  } clr_ctl_t;

endpackage

`default_nettype wire

FILE: src/rcs_tag_ram.sv
// ---------------------------------------------------------------------------
// rcs_tag_ram
// Membership tag memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcs_tag_ram #(
  parameter int DEPTH = rcs_pkg::NODE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = rcs_pkg::EPOCH_BITS
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/rcs_clear_ctl.sv
// ---------------------------------------------------------------------------
// rcs_clear_ctl
// Tag memory sweep sequencer: runs after reset and on epoch wrap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcs_clear_ctl #(
  parameter int NODE_DEPTH = rcs_pkg::NODE_DEPTH_DEF,
  parameter int AW         = $clog2(NODE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wrap,
  output rcs_pkg::clr_ctl_t     ctl,
  output logic         [AW-1:0] addr
);

  rcs_pkg::clr_state_t state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic                last;

  assign last = (cnt_r == AW'(NODE_DEPTH - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcs_pkg::CLR_SWEEP: if (last) state_nxt = rcs_pkg::CLR_RUN;
      rcs_pkg::CLR_RUN:   if (wrap) state_nxt = rcs_pkg::CLR_SWEEP;
      default:            state_nxt = rcs_pkg::CLR_SWEEP;
    endcase
  end

  always_comb begin
    ctl       = '0;
    cnt_nxt   = '0;
    unique case (state_r)
      rcs_pkg::CLR_SWEEP: begin
        ctl.busy  = 1'b1;
        ctl.wr_en = 1'b1;
        cnt_nxt   = last ? '0 : cnt_r + AW'(1);
      end
      rcs_pkg::CLR_RUN: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  assign addr = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcs_pkg::CLR_SWEEP;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/rcs_core_update.sv
// ---------------------------------------------------------------------------
// rcs_core_update
// Core and periphery counters, stop flag, epoch and result formation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcs_core_update #(
  parameter int COUNT_BITS = rcs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [rcs_pkg::EDGE_W-1:0]   cfg_wr_data,
  input  wire logic                         go,
  input  wire rcs_pkg::item_t               item,
  input  wire logic                         hit,
  output rcs_pkg::upd_ctl_t                 ctl,
  output rcs_pkg::result_t                  res
);

  localparam int CW = COUNT_BITS;
  localparam int WW = (CW > rcs_pkg::EDGE_W) ? CW : rcs_pkg::EDGE_W;

  logic [rcs_pkg::EDGE_W-1:0]     edge_total_r;
  logic [CW-1:0]                  core_r, core_nxt;
  logic [CW-1:0]                  periph_r, periph_nxt;
  logic                           stopped_r, stopped_nxt;
  logic [rcs_pkg::EPOCH_BITS-1:0] epoch_r, epoch_nxt;
  logic [WW-1:0]                  et_w;
  logic [WW-1:0]                  cmax_w;
  logic [CW-1:0]                  periph_init;
  logic                           do_start, do_nbr, do_end, epoch_full;

  assign et_w        = WW'(edge_total_r);
  assign cmax_w      = WW'({CW{1'b1}});
  assign periph_init = (et_w > cmax_w) ? CW'(cmax_w) : CW'(et_w);

  assign do_start   = go && (item.mode == rcs_pkg::MODE_START);
  assign do_nbr     = go && (item.mode == rcs_pkg::MODE_NBR) && !stopped_r;
  assign do_end     = go && (item.mode == rcs_pkg::MODE_END);
  assign epoch_full = &epoch_r;

  always_comb begin
    core_nxt    = core_r;
    periph_nxt  = periph_r;
    stopped_nxt = stopped_r;
    epoch_nxt   = epoch_r;
    priority if (do_start) begin
      core_nxt    = '0;
      periph_nxt  = periph_init;
      stopped_nxt = 1'b0;
      epoch_nxt   = epoch_full ? rcs_pkg::EPOCH_BITS'(1) : epoch_r + rcs_pkg::EPOCH_BITS'(1);
    end else if (do_nbr) begin
      if (hit) begin
        if (!(&core_r)) core_nxt = core_r + CW'(1);
      end else if (periph_r != '0) begin
        periph_nxt = periph_r - CW'(1);
      end
    end else if (do_end) begin
      if (!stopped_r && (core_r > periph_r)) stopped_nxt = 1'b1;
    end
  end

  assign ctl.wr_en = do_end && !stopped_r && item.node_ok;
  assign ctl.wrap  = do_start && epoch_full;
  assign ctl.epoch = epoch_r;

  assign res.node   = item.node;
  assign res.joined = !stopped_r;
  assign res.done   = stopped_nxt;
  assign res.core   = rcs_pkg::OUT_CNT_W'(core_r);
  assign res.periph = rcs_pkg::OUT_CNT_W'(periph_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r <= '0;
      core_r       <= '0;
      periph_r     <= '0;
      stopped_r    <= 1'b0;
      epoch_r      <= rcs_pkg::EPOCH_BITS'(1);
    end else begin
      if (cfg_wr_en) edge_total_r <= cfg_wr_data;
      core_r    <= core_nxt;
      periph_r  <= periph_nxt;
      stopped_r <= stopped_nxt;
      epoch_r   <= epoch_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/rich_club_core_select.sv
// ---------------------------------------------------------------------------
// rich_club_core_select
// Streaming rich club core / periphery split over degree-ordered adjacency.
// ---------------------------------------------------------------------------
// Accepted end-of-node transactions pass s1, then the output register.
// Throughput: one transaction per cycle unless stalled (tag sweep, epoch wrap or output stall).
// Reset: sweep over all NODE_DEPTH tag RAM entries, input stalled meanwhile.
// Every 2^8-1 starts the epoch wraps and the same sweep runs again.
// Config writes are taken at any time, also during a sweep.
`timescale 1ns / 1ps
`default_nettype none

module rich_club_core_select #(
  parameter int NODE_DEPTH = rcs_pkg::NODE_DEPTH_DEF,
  parameter int COUNT_BITS = rcs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rcs_pkg::EDGE_W-1:0]      cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [rcs_pkg::MODE_W-1:0]      in_mode,
  input  wire logic [rcs_pkg::ID_W-1:0]        in_node_id,
  input  wire logic [rcs_pkg::ID_W-1:0]        in_neighbor_id,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [rcs_pkg::ID_W-1:0]             out_node_out,
  output logic                                 out_joined_core,
  output logic                                 out_selection_done,
  output logic [rcs_pkg::OUT_CNT_W-1:0]        out_core_edges,
  output logic [rcs_pkg::OUT_CNT_W-1:0]        out_periphery_edges
);

  localparam int AW = $clog2(NODE_DEPTH);
  localparam int XW = (AW > rcs_pkg::ID_W) ? AW : rcs_pkg::ID_W;

  rcs_pkg::item_t                 s1_item_r;
  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_byp_r;
  rcs_pkg::upd_ctl_t              upd;
  rcs_pkg::result_t               res;
  rcs_pkg::result_t               out_res_r;
  logic                           out_valid_r;
  rcs_pkg::clr_ctl_t              clr;
  logic [AW-1:0]                  clr_addr;
  logic [rcs_pkg::EPOCH_BITS-1:0] rd_tag;
  logic                           accept, s1_go, out_adv, hit, wrap_hold;
  logic [XW-1:0]                  in_nbr_x, in_node_x, s1_node_x;
  logic [AW-1:0]                  in_nbr_addr, s1_node_addr;
  logic [AW-1:0]                  ram_waddr;
  logic [rcs_pkg::EPOCH_BITS-1:0] ram_wdata;
  logic                           ram_we;

  assign in_nbr_x     = XW'(in_neighbor_id);
  assign in_node_x    = XW'(in_node_id);
  assign s1_node_x    = XW'(s1_item_r.node);
  assign in_nbr_addr  = in_nbr_x[AW-1:0];
  assign s1_node_addr = s1_node_x[AW-1:0];

  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && ((s1_item_r.mode != rcs_pkg::MODE_END) || out_adv);
  assign wrap_hold = s1_valid_r && (s1_item_r.mode == rcs_pkg::MODE_START) && (&upd.epoch);
  assign in_stall  = clr.busy || (s1_valid_r && !s1_go) || wrap_hold;
  assign accept    = in_valid && !in_stall;

  assign hit = s1_item_r.nbr_ok && ((rd_tag == upd.epoch) || s1_byp_r);

  assign ram_we    = clr.wr_en || upd.wr_en;
  assign ram_waddr = clr.busy ? clr_addr : s1_node_addr;
  assign ram_wdata = clr.busy ? '0 : upd.epoch;

  assign s1_valid_nxt = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  rcs_tag_ram #(
    .DEPTH (NODE_DEPTH),
    .AW    (AW),
    .DW    (rcs_pkg::EPOCH_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_nbr_addr),
    .rdata (rd_tag)
  );

  rcs_clear_ctl #(
    .NODE_DEPTH (NODE_DEPTH),
    .AW         (AW)
  ) u_clr (
    .clk   (clk),
    .rst_n (rst_n),
    .wrap  (upd.wrap),
    .ctl   (clr),
    .addr  (clr_addr)
  );

  rcs_core_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_upd (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go          (s1_go),
    .item        (s1_item_r),
    .hit         (hit),
    .ctl         (upd),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_adv) begin
        out_valid_r <= s1_go && (s1_item_r.mode == rcs_pkg::MODE_END);
      end
    end
  end

  // payload; bypass covers a node write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.mode    <= rcs_pkg::mode_t'(in_mode);
      s1_item_r.node    <= in_node_id;
      s1_item_r.node_ok <= (XW + 1)'(in_node_x) < (XW + 1)'(NODE_DEPTH);
      s1_item_r.nbr_ok  <= (XW + 1)'(in_nbr_x) < (XW + 1)'(NODE_DEPTH);
      s1_byp_r          <= upd.wr_en && (s1_node_addr == in_nbr_addr);
    end
    if (out_adv && s1_go && (s1_item_r.mode == rcs_pkg::MODE_END)) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_node_out        = out_res_r.node;
  assign out_joined_core     = out_res_r.joined;
  assign out_selection_done  = out_res_r.done;
  assign out_core_edges      = out_res_r.core;
  assign out_periphery_edges = out_res_r.periph;

endmodule

`default_nettype wire

FILE: src/rcs_checker.sv
// ---------------------------------------------------------------------------
// rcs_checker
// Port-level checks on the rich club core select result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rich_club_core_select_assert.svh"

module rcs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [rcs_pkg::ID_W-1:0]        out_node_out,
  input wire logic                            out_joined_core,
  input wire logic                            out_selection_done,
  input wire logic [rcs_pkg::OUT_CNT_W-1:0]   out_core_edges,
  input wire logic [rcs_pkg::OUT_CNT_W-1:0]   out_periphery_edges
);

  // held result transaction keeps its payload
  `RCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_node_out) && $stable(out_joined_core) && $stable(out_selection_done) && $stable(out_core_edges) && $stable(out_periphery_edges))

  // a node is refused only once selection has stopped
  `RCS_ASSERT(a_refused_done, out_valid && !out_joined_core, out_selection_done)

  `RCS_ASSERT_RST(a_reset_idle, $past(!rst_n), !out_valid)

endmodule

bind rich_club_core_select rcs_checker u_rcs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_node_out        (out_node_out),
  .out_joined_core     (out_joined_core),
  .out_selection_done  (out_selection_done),
  .out_core_edges      (out_core_edges),
  .out_periphery_edges (out_periphery_edges)
);

`default_nettype wire

FILE: dv/rich_club_core_select_test.sv
// ---------------------------------------------------------------------------
// rich_club_core_select_test
// Self-checking bench for the rich club core select block. A directed
// table covers use before start, stop behavior, counter saturation and
// the id extremes; random graphs with noise and broken sequences follow,
// under three sender/receiver idle mixes and several edge totals. Every
// result transaction is checked against a typed row's fixed value, else an
// in-bench tracker of the core bitmap and the core and periphery edge counters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rich_club_core_select_test;

  localparam int CNT_W      = rcs_pkg::COUNT_BITS_DEF;
  localparam int ID_W       = rcs_pkg::ID_W;
  localparam int EDGE_W     = rcs_pkg::EDGE_W;
  localparam int MODE_W     = rcs_pkg::MODE_W;
  localparam int OUT_CNT_W  = rcs_pkg::OUT_CNT_W;
  localparam int SETTLE     = 8;
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_ITEMS  = 250;
  localparam int PHASE_STARTS = 45;

  typedef enum bit {ROW_TXN, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    rcs_pkg::mode_t     mode;
    logic [ID_W-1:0]    node;
    logic [ID_W-1:0]    nbr;
    logic [EDGE_W-1:0]  cfg_val;
    bit                 typed;
    rcs_pkg::result_t   res;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [EDGE_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode;
  logic [ID_W-1:0]      in_node_id;
  logic [ID_W-1:0]      in_neighbor_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [ID_W-1:0]      out_node_out;
  logic                 out_joined_core;
  logic                 out_selection_done;
  logic [OUT_CNT_W-1:0] out_core_edges;
  logic [OUT_CNT_W-1:0] out_periphery_edges;

  // tracker state
  bit [rcs_pkg::NODE_DEPTH_DEF-1:0] core_map;
  logic [CNT_W-1:0]       core_cnt;
  logic [CNT_W-1:0]       periph_cnt;
  bit                     halted;
  logic [EDGE_W-1:0]      edge_cfg;

  rcs_pkg::result_t finish_q[$];
  dir_row_t         dir_tab[$];
  int      errs;
  int      cycles;
  int      items_sent;
  int      starts_sent;
  int      send_idle_pct;
  int      stall_pct;
  bit      long_hold;

  rich_club_core_select u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_node_id          (in_node_id),
    .in_neighbor_id      (in_neighbor_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_node_out        (out_node_out),
    .out_joined_core     (out_joined_core),
    .out_selection_done  (out_selection_done),
    .out_core_edges      (out_core_edges),
    .out_periphery_edges (out_periphery_edges)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void add_row(input dir_row_t row);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // core bitmap and edge counters; returns 1 when the transaction finishes a node
  function automatic bit track_core(input rcs_pkg::mode_t m, input logic [ID_W-1:0] node,
                                    input logic [ID_W-1:0] nbr,
                                    output rcs_pkg::result_t r);
    r = '0;
    unique case (m)
      rcs_pkg::MODE_START: begin
        core_map   = '0;
        core_cnt   = '0;
        periph_cnt = edge_cfg;
        halted     = 1'b0;
        return 1'b0;
      end
      rcs_pkg::MODE_NBR: begin
        if (!halted) begin
          if (core_map[nbr]) begin
            if (core_cnt != '1) core_cnt = core_cnt + 1'b1;
          end else if (periph_cnt != '0) begin
            periph_cnt = periph_cnt - 1'b1;
          end
        end
        return 1'b0;
      end
      rcs_pkg::MODE_END: begin
        r.joined = !halted;
        if (!halted) begin
          core_map[node] = 1'b1;
          if (core_cnt > periph_cnt) halted = 1'b1;
        end
        r.node   = node;
        r.done   = halted;
        r.core   = core_cnt[OUT_CNT_W-1:0];
        r.periph = periph_cnt[OUT_CNT_W-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_txn(input rcs_pkg::mode_t m, input logic [ID_W-1:0] node,
                          input logic [ID_W-1:0] nbr, input bit typed = 1'b0,
                          input rcs_pkg::result_t fixed = '0);
    rcs_pkg::result_t r;
    bit               has;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_node_id     <= node;
    in_neighbor_id <= nbr;
    do @(posedge clk); while (in_stall !== 1'b0);
    has = track_core(m, node, nbr, r);
    if (has) finish_q.insert(finish_q.size(), typed ? fixed : r);
    if (m != rcs_pkg::MODE_NOP) items_sent++;
    if (m == rcs_pkg::MODE_START) starts_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (finish_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_edge_total(input logic [EDGE_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    edge_cfg  = v;
  endtask

  // one graph: start, a few nodes drawn from a small id pool, neighbors mostly from the pool
  task automatic send_graph();
    logic [ID_W-1:0] pool [6];
    logic [ID_W-1:0] id;
    int              n_nodes;
    int              n_nbrs;
    foreach (pool[i]) pool[i] = ID_W'($urandom);
    push_txn(rcs_pkg::MODE_START, ID_W'($urandom), ID_W'($urandom));
    n_nodes = $urandom_range(1, 3);
    for (int i = 0; i < n_nodes; i++) begin
      n_nbrs = $urandom_range(0, 3);
      for (int j = 0; j < n_nbrs; j++) begin
        id = ($urandom_range(0, 7) != 0) ? pool[$urandom_range(0, 5)] : ID_W'($urandom);
        push_txn(rcs_pkg::MODE_NBR, ID_W'($urandom), id);
      end
      push_txn(rcs_pkg::MODE_END, pool[$urandom_range(0, 5)], ID_W'($urandom));
    end
  endtask

  // receiver: random stall, or a long hold-off when requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rcs_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (finish_q.size() == 0) begin
        $error("unexpected result transaction, node_out %0d", out_node_out);
        errs++;
      end else begin
        want = finish_q.pop_front();
        if (out_node_out !== want.node) begin
          $error("node_out exp %0d got %0d", want.node, out_node_out);
          errs++;
        end
        if (out_joined_core !== want.joined) begin
          $error("joined_core exp %0d got %0d", want.joined, out_joined_core);
          errs++;
        end
        if (out_selection_done !== want.done) begin
          $error("selection_done exp %0d got %0d", want.done, out_selection_done);
          errs++;
        end
        if (out_core_edges !== want.core) begin
          $error("core_edges exp %0d got %0d", want.core, out_core_edges);
          errs++;
        end
        if (out_periphery_edges !== want.periph) begin
          $error("periphery_edges exp %0d got %0d", want.periph, out_periphery_edges);
          errs++;
        end
      end
    end
  end

  initial begin
    int              send_pct_tab[3];
    int              stall_pct_tab[3];
    logic [EDGE_W-1:0] phase_total[6];
    int              phase_items;
    int              phase_starts;
    bit              paused;

    send_pct_tab  = '{31, 69, 0};
    stall_pct_tab = '{69, 31, 0};
    phase_total   = '{16'd0, 16'd2, 16'd6, 16'd15, 16'hFFFF, EDGE_W'($urandom)};

    core_map   = '0;
    core_cnt   = '0;
    periph_cnt = '0;
    halted     = 1'b0;
    edge_cfg   = '0;
    long_hold  = 1'b0;
    send_idle_pct = send_pct_tab[0];
    stall_pct     = stall_pct_tab[0];

    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_mode        <= rcs_pkg::MODE_NOP;
    in_node_id     <= '0;
    in_neighbor_id <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // before any start: runs on reset state, edge total 0
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'd5, 10'd0, 16'd0, 1'b1,
              '{10'd5, 1'b1, 1'b0, 16'd0, 16'd0}});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'd0, 10'd5, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'd1023, 10'd0, 16'd0, 1'b1,
              '{10'd1023, 1'b1, 1'b1, 16'd1, 16'd0}});
    // stopped: end reports not joined, neighbor ignored
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'd0, 10'd1023, 16'd0, 1'b1,
              '{10'd0, 1'b0, 1'b1, 16'd1, 16'd0}});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'd1023, 10'd1023, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_NOP, 10'd1023, 10'd1023, 16'd0, 1'b0, '0});
    // periphery saturates at zero
    add_row('{ROW_TXN, rcs_pkg::MODE_START, 10'd1023, 10'd1023, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'd0, 10'd1023, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'd0, 10'd0, 16'd0, 1'b1,
              '{10'd0, 1'b1, 1'b0, 16'd0, 16'd0}});
    // largest edge total
    add_row('{ROW_CFG, rcs_pkg::MODE_NOP, 10'd0, 10'd0, 16'hFFFF, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_START, 10'd0, 10'd0, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'd0, 10'd1023, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'd1023, 10'd1023, 16'd0, 1'b1,
              '{10'd1023, 1'b1, 1'b0, 16'd0, 16'd65534}});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'd1023, 10'd1023, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'd1023, 10'd0, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'd0, 10'd0, 16'd0, 1'b0, '0});
    // small edge total, stop on a core edge
    add_row('{ROW_CFG, rcs_pkg::MODE_NOP, 10'd0, 10'd0, 16'd1, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_START, 10'h155, 10'h2AA, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'h2AA, 10'h155, 16'd0, 1'b1,
              '{10'h2AA, 1'b1, 1'b0, 16'd0, 16'd1}});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'h155, 10'h2AA, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'h155, 10'h2AA, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_NBR, 10'h2AA, 10'h155, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_END, 10'h3FF, 10'h000, 16'd0, 1'b0, '0});
    add_row('{ROW_TXN, rcs_pkg::MODE_NOP, 10'h000, 10'h3FF, 16'd0, 1'b0, '0});

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        set_edge_total(dir_tab[i].cfg_val);
      else
        push_txn(dir_tab[i].mode, dir_tab[i].node, dir_tab[i].nbr,
                 dir_tab[i].typed, dir_tab[i].res);
    end

    for (int p = 0; p < 6; p++) begin
      set_edge_total(phase_total[p]);
      send_idle_pct = send_pct_tab[p / 2];
      stall_pct     = stall_pct_tab[p / 2];
      if (p == 0 || p == 4) long_hold = 1'b1;
      phase_items  = items_sent;
      phase_starts = starts_sent;
      paused       = 1'b0;
      while (items_sent - phase_items < PHASE_ITEMS ||
             starts_sent - phase_starts < PHASE_STARTS) begin
        if (p == 3 && !paused && items_sent - phase_items >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 85)
          send_graph();
        else
          push_txn(rcs_pkg::mode_t'($urandom_range(0, 3)), ID_W'($urandom),
                   ID_W'($urandom));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errs == 0 && finish_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
